// ===== rtl/core/cbm_pkg.sv =====
// Shared types, codes and address constants for the cartridge bank mapper.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  // Default sizes of the attached ROM image and SRAM.
  localparam int ROM_BANKS_DEF  = 128;
  localparam int SRAM_BYTES_DEF = 16384;

  // Field widths.
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int PHYS_W = 20;

  // Access kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Target codes.
  typedef logic [1:0] target_t;
  localparam target_t TGT_OPEN = 2'd0;
  localparam target_t TGT_SRAM = 2'd1;
  localparam target_t TGT_ROM  = 2'd2;

  // CPU address map.
  localparam logic [ADDR_W-1:0] ADDR_ROM_LO   = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_ROM_HI   = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_SUB0_SEL = 16'h77FF;
  localparam logic [ADDR_W-1:0] ADDR_SUB1_SEL = 16'h7FFF;
  localparam logic [3:0]        SUB_WINDOW_NIB = 4'h7;
  localparam logic [12:0]       BANK_SEL_OFS  = 13'h0FFF;
  localparam logic [2:0]        FIRST_ROM_SLOT = 3'd2;
  localparam int                ENABLE_BIT    = 7;

  // Architectural mapper state.
  typedef struct packed {
    logic [3:0][DATA_W-1:0] bank;
    logic [1:0][DATA_W-1:0] sub_bank;
    logic                   sram_en;
    logic                   sub_en;
  } map_state_t;

  // One translated access.
  typedef struct packed {
    target_t           target;
    logic [PHYS_W-1:0] phys;
    logic              strobe;
  } xlate_t;

endpackage

`default_nettype wire

// ===== rtl/core/cartridge_bank_mapper_with_submapper_core.sv =====
// Top level of the cartridge bank mapper: input register, translation and result register.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one CPU bus access per transfer:
//   kind (0 read, 1 write), bus_address and write_byte. The output channel
//   (out_valid/out_ready) returns one translated result per access: target
//   (open bus, SRAM or ROM), physical_address and sram_write_strobe.
//   An accepted access waits in the input register and moves into the result
//   register when that register is empty or its result is being taken.
//   Throughput: one access per cycle while the receiver does not stall;
//   translation is one pass of short logic between the input and result registers.
//   Register writes (bank, sub-bank, enables) take effect at the edge where the
//   access moves into the result register, so the next access already sees them.
//   Reset clears all bank registers, both sub-bank registers and both enables,
//   and empties both pipeline registers.
//   When the receiver stalls, the result holds and the input register keeps one
//   more access; in_ready drops only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_with_submapper_core #(
  parameter int ROM_BANKS  = cbm_pkg::ROM_BANKS_DEF,
  parameter int SRAM_BYTES = cbm_pkg::SRAM_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       kind,
  input  wire logic [cbm_pkg::ADDR_W-1:0] bus_address,
  input  wire logic [cbm_pkg::DATA_W-1:0] write_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output cbm_pkg::target_t                target,
  output logic [cbm_pkg::PHYS_W-1:0]      physical_address,
  output logic                            sram_write_strobe
);

  logic                       s1_valid;
  logic                       s1_kind;
  logic [cbm_pkg::ADDR_W-1:0] s1_addr;
  logic [cbm_pkg::DATA_W-1:0] s1_data;
  logic                       adv;
  cbm_pkg::map_state_t        st;
  cbm_pkg::xlate_t            res;

  // The held access moves on when the result register is empty or being taken.
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind <= kind;
      s1_addr <= bus_address;
      s1_data <= write_byte;
    end
  end

  cbm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (adv),
    .kind        (s1_kind),
    .bus_address (s1_addr),
    .write_byte  (s1_data),
    .st          (st)
  );

  cbm_xlate #(
    .ROM_BANKS  (ROM_BANKS),
    .SRAM_BYTES (SRAM_BYTES)
  ) u_xlate (
    .kind        (s1_kind),
    .bus_address (s1_addr),
    .st          (st),
    .res         (res)
  );

  // Result register payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      target            <= res.target;
      physical_address  <= res.phys;
      sram_write_strobe <= res.strobe;
    end
  end

`ifndef SYNTH
  a_strobe_only_sram: assert property (@(posedge clk) disable iff (rst)
    out_valid && sram_write_strobe |-> target == cbm_pkg::TGT_SRAM)
    else $error("SRAM write strobe without SRAM target");

  a_sram_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == cbm_pkg::TGT_SRAM |->
      physical_address < cbm_pkg::PHYS_W'(SRAM_BYTES))
    else $error("SRAM offset beyond SRAM size");

  a_open_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == cbm_pkg::TGT_OPEN |->
      physical_address == '0 && !sram_write_strobe)
    else $error("open bus result carries a nonzero payload");

  a_reset_enables: assert property (@(posedge clk)
    rst |=> !st.sram_en && !st.sub_en)
    else $error("enables not cleared by reset");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("advanced access did not reach the result register");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cbm_regs.sv =====
// Bank, sub-bank and enable registers with their write decode.
`timescale 1ns / 1ps
`default_nettype none

module cbm_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic                       kind,
  input  wire logic [cbm_pkg::ADDR_W-1:0] bus_address,
  input  wire logic [cbm_pkg::DATA_W-1:0] write_byte,
  output cbm_pkg::map_state_t             st
);

  logic                   is_wr;
  logic [2:0]             slot_full;
  logic [1:0]             slot;
  logic [3:0][7:0]        bank;
  logic [1:0][7:0]        sub_bank;
  logic                   sram_en;
  logic                   sub_en;

  // A write lands only inside the banked ROM window.
  assign is_wr = wr_en && (kind == cbm_pkg::KIND_WRITE) &&
                 (bus_address >= cbm_pkg::ADDR_ROM_LO) &&
                 (bus_address < cbm_pkg::ADDR_ROM_HI);
  assign slot_full = bus_address[15:13] - cbm_pkg::FIRST_ROM_SLOT;
  assign slot      = slot_full[1:0];

  // Sub-bank selects take priority over the bank select pattern.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank     <= '0;
      sub_bank <= '0;
      sram_en  <= 1'b0;
      sub_en   <= 1'b0;
    end else if (is_wr) begin
      if (bus_address == cbm_pkg::ADDR_SUB0_SEL) begin
        sub_bank[0] <= write_byte;
      end else if (bus_address == cbm_pkg::ADDR_SUB1_SEL) begin
        sub_bank[1] <= write_byte;
      end else if (bus_address[12:0] == cbm_pkg::BANK_SEL_OFS) begin
        bank[slot] <= write_byte;
        if (slot == 2'd0) begin
          sram_en <= write_byte[cbm_pkg::ENABLE_BIT];
        end
        if (slot == 2'd1) begin
          sub_en <= write_byte[cbm_pkg::ENABLE_BIT];
        end
      end
    end
  end

  assign st.bank     = bank;
  assign st.sub_bank = sub_bank;
  assign st.sram_en  = sram_en;
  assign st.sub_en   = sub_en;

endmodule

`default_nettype wire

// ===== rtl/core/cbm_xlate.sv =====
// Address translation from a CPU access to target and physical offset.
`timescale 1ns / 1ps
`default_nettype none

module cbm_xlate #(
  parameter int ROM_BANKS  = cbm_pkg::ROM_BANKS_DEF,
  parameter int SRAM_BYTES = cbm_pkg::SRAM_BYTES_DEF
) (
  input  wire logic                       kind,
  input  wire logic [cbm_pkg::ADDR_W-1:0] bus_address,
  input  wire cbm_pkg::map_state_t        st,
  output cbm_pkg::xlate_t                 res
);

  localparam logic [17:0] SRAM_SIZE = 18'(SRAM_BYTES);
  localparam logic [9:0]  ROM_SIZE  = 10'(ROM_BANKS);

  logic [2:0]                 slot_full;
  logic [1:0]                 slot;
  logic [17:0]                sram_rem;
  logic [9:0]                 bank_rem;
  logic [20:0]                rom_full;
  logic [cbm_pkg::PHYS_W-1:0] sub_phys;

  assign slot_full = bus_address[15:13] - cbm_pkg::FIRST_ROM_SLOT;
  assign slot      = slot_full[1:0];

  // SRAM offset: restoring remainder, four quotient bits cover the 16 KB window.
  always_comb begin
    sram_rem = {4'd0, bus_address[13:0]};
    for (int j = 3; j >= 0; j--) begin
      if (sram_rem >= (SRAM_SIZE << j)) begin
        sram_rem = sram_rem - (SRAM_SIZE << j);
      end
    end
  end

  // Bank number wraps modulo the ROM bank count; two steps cover a byte.
  always_comb begin
    bank_rem = {2'd0, st.bank[slot]};
    for (int j = 1; j >= 0; j--) begin
      if (bank_rem >= (ROM_SIZE << j)) begin
        bank_rem = bank_rem - (ROM_SIZE << j);
      end
    end
  end

  assign rom_full = {bank_rem[7:0], bus_address[12:0]};
  // Sub-mapper pages sit in the upper half of a 1 MB image.
  assign sub_phys = {1'b1, st.sub_bank[bus_address[11]], bus_address[10:0]};

  // Select the target in the same order of precedence as the bus decode.
  always_comb begin
    res.target = cbm_pkg::TGT_OPEN;
    res.phys   = '0;
    res.strobe = 1'b0;
    if (bus_address < cbm_pkg::ADDR_ROM_LO) begin
      if (st.sram_en) begin
        res.target = cbm_pkg::TGT_SRAM;
        res.phys   = cbm_pkg::PHYS_W'(sram_rem);
        res.strobe = (kind == cbm_pkg::KIND_WRITE);
      end
    end else if (bus_address < cbm_pkg::ADDR_ROM_HI && kind == cbm_pkg::KIND_READ) begin
      res.target = cbm_pkg::TGT_ROM;
      if (st.sub_en && bus_address[15:12] == cbm_pkg::SUB_WINDOW_NIB) begin
        res.phys = sub_phys;
      end else begin
        res.phys = rom_full[cbm_pkg::PHYS_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/cartridge_bank_mapper_with_submapper_core_tb.sv =====
// Self-checking testbench for the cartridge bank mapper core with sub-mapper shadowing.
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_submapper_core_tb;
  import cbm_pkg::*;

  localparam int ROM_BANKS    = ROM_BANKS_DEF;
  localparam int SRAM_BYTES   = SRAM_BYTES_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASES       = 4;
  localparam int HOLD_CYCLES  = 250;

  // Address constants of the sub-mapper window and its ROM region.
  localparam logic [PHYS_W-1:0] SUB_REGION_BASE = 20'h80000;
  localparam int                SUB_BANK_SIZE   = 'h800;
  localparam logic [ADDR_W-1:0] SUB_WIN_LO      = 16'h7000;
  localparam logic [ADDR_W-1:0] SUB_WIN_MID     = 16'h7800;

  // Predicts the translation of each accepted access and checks results in order.
  class xlate_scoreboard;
    typedef struct {
      target_t           tgt;
      logic [PHYS_W-1:0] phys;
      logic              strobe;
    } xlate_exp_t;

    xlate_exp_t      pending_xlates[$];
    logic [7:0]      bank[4];
    logic [7:0]      sub_bank[2];
    bit              sram_en;
    bit              sub_en;
    int              errors;
    int              accesses;
    int              results;
    int              sram_hits;
    int              rom_hits;
    int              window_hits;
    int              open_hits;

    function new();
      for (int i = 0; i < 4; i++) bank[i] = '0;
      sub_bank[0] = '0;
      sub_bank[1] = '0;
      sram_en = 0;
      sub_en = 0;
    endfunction

    function int pending();
      return pending_xlates.size();
    endfunction

    // Work out the result of one accepted access and update the mapper state.
    function void note_access(logic k, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
      xlate_exp_t e;
      int         slot;
      int         phys;
      e.tgt = TGT_OPEN;
      e.phys = '0;
      e.strobe = 1'b0;
      slot = int'(a[15:13]) - 2;
      accesses++;
      if (a < ADDR_ROM_LO) begin
        if (sram_en) begin
          e.tgt = TGT_SRAM;
          e.phys = PHYS_W'(int'(a) % SRAM_BYTES);
          e.strobe = (k == KIND_WRITE);
        end
      end else if (a >= ADDR_ROM_HI) begin
        // Upper page is always open bus.
      end else if (k == KIND_WRITE) begin
        if (a == ADDR_SUB0_SEL) begin
          sub_bank[0] = d;
        end else if (a == ADDR_SUB1_SEL) begin
          sub_bank[1] = d;
        end else if (a[12:0] == BANK_SEL_OFS) begin
          bank[slot] = d;
          if (slot == 0) sram_en = d[ENABLE_BIT];
          else if (slot == 1) sub_en = d[ENABLE_BIT];
        end
      end else if (sub_en && a >= SUB_WIN_LO && a < ADDR_ROM_LO + 16'h4000) begin
        // Sub-mapper shadows the 0x7000 window from the upper half of ROM.
        phys = int'(SUB_REGION_BASE) + int'(sub_bank[a >= SUB_WIN_MID]) * SUB_BANK_SIZE
               + int'(a[10:0]);
        e.tgt = TGT_ROM;
        e.phys = PHYS_W'(phys);
        window_hits++;
      end else begin
        phys = (int'(bank[slot]) % ROM_BANKS) * 'h2000 + int'(a[12:0]);
        e.tgt = TGT_ROM;
        e.phys = PHYS_W'(phys);
      end
      if (e.tgt == TGT_SRAM) sram_hits++;
      else if (e.tgt == TGT_ROM) rom_hits++;
      else open_hits++;
      pending_xlates.push_back(e);
    endfunction

    // Compare one result transfer against the oldest expected translation.
    function void check_result(target_t t, logic [PHYS_W-1:0] p, logic s);
      xlate_exp_t e;
      results++;
      if (pending_xlates.size() == 0) begin
        $display("%0t: result with no access pending: target %0d phys %05h strobe %0b",
                 $time, t, p, s);
        errors++;
        return;
      end
      e = pending_xlates.pop_front();
      if (t !== e.tgt) begin
        $display("%0t: target mismatch: expected %0d, actual %0d", $time, e.tgt, t);
        errors++;
      end
      if (p !== e.phys) begin
        $display("%0t: physical_address mismatch: expected %05h, actual %05h",
                 $time, e.phys, p);
        errors++;
      end
      if (s !== e.strobe) begin
        $display("%0t: sram_write_strobe mismatch: expected %0b, actual %0b",
                 $time, e.strobe, s);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = 1'b0;
  logic [ADDR_W-1:0] bus_address = '0;
  logic [DATA_W-1:0] write_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  target_t           target;
  logic [PHYS_W-1:0] physical_address;
  logic              sram_write_strobe;

  xlate_scoreboard sb = new();

  // Idle controls for the sender and the receiver, and the receiver's hold-off request.
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req = 1'b0;

  cartridge_bank_mapper_with_submapper_core #(
    .ROM_BANKS(ROM_BANKS),
    .SRAM_BYTES(SRAM_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .bus_address(bus_address),
    .write_byte(write_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .target(target),
    .physical_address(physical_address),
    .sram_write_strobe(sram_write_strobe)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length: mostly short, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one access and wait for its transfer; payload changes only at falling edges.
  task automatic send_access(logic k, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    int gap;
    gap = 0;
    if (send_idle && $urandom_range(0, 2) == 0) gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    bus_address = a;
    write_byte = d;
    do @(posedge clk); while (!in_ready);
    sb.note_access(k, a, d);
  endtask

  // One random access, weighted toward sequences that change the mapping.
  task automatic send_random();
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic              k;
    int                pick;
    pick = $urandom_range(0, 99);
    a = 16'($urandom);
    d = 8'($urandom);
    k = 1'($urandom);
    if (pick < 20) begin
      // Bank select write in one of the four slots.
      k = KIND_WRITE;
      a = ADDR_ROM_LO + 16'($urandom_range(0, 3) * 'h2000) + 16'(BANK_SEL_OFS);
    end else if (pick < 30) begin
      k = KIND_WRITE;
      a = $urandom_range(0, 1) ? ADDR_SUB1_SEL : ADDR_SUB0_SEL;
    end else if (pick < 45) begin
      a = {2'b00, a[13:0]};
    end else if (pick < 70) begin
      k = KIND_READ;
      a = ADDR_ROM_LO + 16'($urandom_range(0, 'h7FFF));
    end else if (pick < 80) begin
      k = KIND_READ;
      a = SUB_WIN_LO + 16'($urandom_range(0, 'hFFF));
    end else if (pick < 90) begin
      // Near misses of the register addresses, and writes that must be ignored.
      k = KIND_WRITE;
      case ($urandom_range(0, 3))
        0: a = {a[15:13], 13'h0FFE};
        1: a = {a[15:13], 13'h1FFF};
        2: a = {a[15:13], 13'h0FFF} | 16'hC000;
        default: a = ADDR_ROM_LO + 16'($urandom_range(0, 'h7FFF));
      endcase
    end
    send_access(k, a, d);
  endtask

  // Drain: the sender waits here until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Receiver: check each result transfer, then choose out_ready for the next edge.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(target, physical_address, sram_write_strobe);
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Stimulus and final verdict.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset state, every region, register writes and both enables.
    send_access(KIND_READ, 16'h0000, 8'h00);
    send_access(KIND_WRITE, 16'h3FFF, 8'hFF);
    send_access(KIND_READ, 16'h4000, 8'hFF);
    send_access(KIND_READ, 16'hBFFF, 8'h00);
    send_access(KIND_READ, 16'hC000, 8'h00);
    send_access(KIND_WRITE, 16'hFFFF, 8'hFF);
    send_access(KIND_WRITE, 16'h4FFF, 8'h85);
    send_access(KIND_READ, 16'h0000, 8'h00);
    send_access(KIND_WRITE, 16'h3FFF, 8'hAA);
    send_access(KIND_READ, 16'h4123, 8'h00);
    send_access(KIND_WRITE, 16'h6FFF, 8'hFF);
    send_access(KIND_WRITE, 16'h77FF, 8'h00);
    send_access(KIND_WRITE, 16'h7FFF, 8'hFF);
    send_access(KIND_READ, 16'h7000, 8'h00);
    send_access(KIND_READ, 16'h77FF, 8'h00);
    send_access(KIND_READ, 16'h7800, 8'h00);
    send_access(KIND_READ, 16'h7FFF, 8'h00);
    send_access(KIND_READ, 16'h6FFF, 8'h00);
    send_access(KIND_WRITE, 16'h8FFF, 8'h80);
    send_access(KIND_WRITE, 16'hAFFF, 8'h7F);
    send_access(KIND_READ, 16'h9000, 8'h00);
    send_access(KIND_WRITE, 16'h5FFF, 8'h12);
    send_access(KIND_WRITE, 16'hCFFF, 8'h34);
    send_access(KIND_WRITE, 16'h4FFF, 8'h00);
    send_access(KIND_WRITE, 16'h6FFF, 8'h01);
    send_access(KIND_READ, 16'h7000, 8'h00);
    wait_drained();

    // Random phases: normal idling, long receiver hold-off with no sender idling, no idling, normal idling again.
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle = (ph != 1) && (ph != 2);
      recv_idle = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) send_random();
      wait_drained();
    end

    $display("Covered %0d accesses and %0d results: %0d SRAM, %0d ROM (%0d sub-window),",
             sb.accesses, sb.results, sb.sram_hits, sb.rom_hits, sb.window_hits);
    $display("and %0d open bus, under idling, stalls and a long receiver hold-off.",
             sb.open_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cbm_pkg.sv
rtl/core/cbm_regs.sv
rtl/core/cbm_xlate.sv
rtl/core/cartridge_bank_mapper_with_submapper_core.sv
test/cartridge_bank_mapper_with_submapper_core_tb.sv
